/* rtl/core/aflt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aflt_pkg: shared definitions for the audio FIFO level trim loop
// Default widths, filter factors, register map and controller interface types.
// ----------------------------------------------------------------------------
package aflt_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 24;

	// Filter factors in Q0.16.
	localparam int K_BITS = 16;
	localparam int FAST_K = 19660;
	localparam int SLOW_K = 1310;
	localparam int SLEW_K = 6553;

	// Register indexes (word address bit 2).
	localparam logic REG_TARGET_LEVEL = 1'b0;
	localparam logic REG_MAX_TRIM     = 1'b1;

	typedef enum logic [1:0] {
		MUL_FILT = 2'd0,
		MUL_SQR  = 2'd1,
		MUL_CUBE = 2'd2,
		MUL_SLEW = 2'd3
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     div_init;
		logic     div_step;
		logic     fill_load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     smooth_upd;
		logic     goal_load;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic inactive;
		logic skip;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

/* rtl/core/aflt_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aflt_regs: configuration register bank
// Holds the target fill level and the trim limit, written over the APB port.
// ----------------------------------------------------------------------------
module aflt_regs #(
	parameter int FRAC_BITS = aflt_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic [FRAC_BITS:0]   target_level,
	output logic [FRAC_BITS-1:0] max_trim
);

	localparam longint ONE_L = longint'(1) << FRAC_BITS;

	logic [FRAC_BITS:0]   target_q;
	logic [FRAC_BITS-1:0] max_trim_q;
	logic                 wr_en;

	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= (FRAC_BITS+1)'(ONE_L / 2);
			max_trim_q <= FRAC_BITS'(ONE_L / 100);
		end else if (wr_en) begin
			unique case (paddr[2])
				aflt_pkg::REG_TARGET_LEVEL: target_q   <= pwdata[FRAC_BITS:0];
				aflt_pkg::REG_MAX_TRIM:     max_trim_q <= pwdata[FRAC_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			aflt_pkg::REG_TARGET_LEVEL: prdata = 32'(target_q);
			aflt_pkg::REG_MAX_TRIM:     prdata = 32'(max_trim_q);
			default:                    prdata = '0;
		endcase
	end

	assign target_level = target_q;
	assign max_trim     = max_trim_q;

endmodule

/* rtl/core/aflt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aflt_ctrl: sequencer for the trim loop
// Steps one word through divide, filter, cubic error, clamp and slew, or straight to output when inactive or skipped.
// ----------------------------------------------------------------------------
module aflt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  aflt_pkg::sts_t sts,
	output aflt_pkg::cmd_t cmd
);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_CHECK = 11'b000_0000_0010,
		S_DIV   = 11'b000_0000_0100,
		S_FILL  = 11'b000_0000_1000,
		S_MULK  = 11'b000_0001_0000,
		S_UPDS  = 11'b000_0010_0000,
		S_SQR   = 11'b000_0100_0000,
		S_CUBE  = 11'b000_1000_0000,
		S_GOAL  = 11'b001_0000_0000,
		S_SLEW  = 11'b010_0000_0000,
		S_OUT   = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign item_stall = (state_q != S_IDLE);

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.mul_sel = aflt_pkg::MUL_FILT;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.inactive || sts.skip) begin
					state_d = S_OUT;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_FILL;
				end
			end
			S_FILL: begin
				cmd.fill_load = 1'b1;
				state_d       = S_MULK;
			end
			S_MULK: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = aflt_pkg::MUL_FILT;
				state_d     = S_UPDS;
			end
			S_UPDS: begin
				cmd.smooth_upd = 1'b1;
				state_d        = S_SQR;
			end
			S_SQR: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = aflt_pkg::MUL_SQR;
				state_d     = S_CUBE;
			end
			S_CUBE: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = aflt_pkg::MUL_CUBE;
				state_d     = S_GOAL;
			end
			S_GOAL: begin
				cmd.goal_load = 1'b1;
				state_d       = S_SLEW;
			end
			S_SLEW: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = aflt_pkg::MUL_SLEW;
				state_d     = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/aflt_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aflt_dp: trim loop datapath
// Radix-2 fill divider, one shared registered multiplier, loop state and
// the result register.
// ----------------------------------------------------------------------------
module aflt_dp #(
	parameter int COUNT_BITS = aflt_pkg::COUNT_BITS_DEF,
	parameter int FRAC_BITS  = aflt_pkg::FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  aflt_pkg::cmd_t         cmd,
	output aflt_pkg::sts_t         sts,
	input  logic                   machine_running,
	input  logic                   fast_forward,
	input  logic                   audio_enabled,
	input  logic                   device_started,
	input  logic [COUNT_BITS-1:0]  buffered_samples,
	input  logic [COUNT_BITS-1:0]  ring_capacity,
	input  logic [FRAC_BITS:0]     target_level,
	input  logic [FRAC_BITS-1:0]   max_trim,
	input  logic                   result_stall,
	output logic                   result_valid,
	output logic signed [FRAC_BITS:0] trim_value,
	output logic                   trim_write
);

	localparam int     F      = FRAC_BITS;
	localparam int     MW     = F + 3;
	localparam int     PW     = 2 * MW;
	localparam int     CW     = $clog2(F);
	localparam int     KB     = aflt_pkg::K_BITS;
	localparam longint ONE_L  = longint'(1) << F;
	localparam longint NEAR_L = (ONE_L * 15) / 100;

	localparam logic signed [F+1:0] NEAR_S = (F+2)'(NEAR_L);
	localparam logic signed [MW-1:0] FAST_S = MW'(aflt_pkg::FAST_K);
	localparam logic signed [MW-1:0] SLOW_S = MW'(aflt_pkg::SLOW_K);
	localparam logic signed [MW-1:0] SLEW_S = MW'(aflt_pkg::SLEW_K);

	logic                   inactive_q, skip_q, sat_q;
	logic [COUNT_BITS-1:0]  queued_q, cap_q, rem_q;
	logic [F-1:0]           quo_q;
	logic [CW-1:0]          cnt_q;
	logic [F:0]             fill_q, smooth_q;
	logic                   lvl_valid_q;
	logic signed [F:0]      trim_q, goal_q;
	logic signed [F+1:0]    e_q;
	logic signed [PW-1:0]   prod_q;
	logic                   out_valid_q, out_write_q;
	logic signed [F:0]      out_value_q;

	logic [COUNT_BITS:0]    shifted, div_sub;
	logic                   div_ge;
	logic [F:0]             fill_d;
	logic signed [F+1:0]    band_d, band_abs, diff, err, slew_d, smooth_sum;
	logic                   fast;
	logic signed [MW-1:0]   sq, mul_a, mul_b;
	logic signed [F+4:0]    cube, dbl, mt, clamped;
	logic signed [F:0]      goal_d, trim_run;

	// Unless saturated, the remainder stays below the capacity; one spare bit holds the doubled value.
	assign shifted = {rem_q, 1'b0};
	assign div_ge  = shifted >= {1'b0, cap_q};
	assign div_sub = shifted - {1'b0, cap_q};
	assign fill_d  = sat_q ? {1'b1, {F{1'b0}}} : {1'b0, quo_q};

	assign band_d   = $signed({1'b0, fill_q}) - $signed({1'b0, target_level});
	assign band_abs = band_d[F+1] ? -band_d : band_d;
	assign fast     = band_abs > NEAR_S;
	assign diff     = $signed({1'b0, fill_q}) - $signed({1'b0, smooth_q});
	assign err      = $signed({1'b0, smooth_q}) - $signed({1'b0, target_level});

	assign smooth_sum = $signed({1'b0, smooth_q}) + (F+2)'(prod_q >>> KB);
	assign sq         = MW'(prod_q >>> F);
	assign cube       = (F+5)'(prod_q >>> F);
	assign dbl        = cube <<< 1;
	assign mt         = $signed({5'b0, max_trim});

	always_comb begin
		if (dbl > mt) begin
			clamped = mt;
		end else if (dbl < -mt) begin
			clamped = -mt;
		end else begin
			clamped = dbl;
		end
	end

	assign goal_d   = (F+1)'(clamped);
	assign slew_d   = $signed({goal_q[F], goal_q}) - $signed({trim_q[F], trim_q});
	assign trim_run = trim_q + (F+1)'(prod_q >>> KB);

	always_comb begin
		case (cmd.mul_sel)
			aflt_pkg::MUL_FILT: begin
				mul_a = MW'(diff);
				mul_b = fast ? FAST_S : SLOW_S;
			end
			aflt_pkg::MUL_SQR: begin
				mul_a = MW'(err);
				mul_b = MW'(err);
			end
			aflt_pkg::MUL_CUBE: begin
				mul_a = sq;
				mul_b = MW'(e_q);
			end
			aflt_pkg::MUL_SLEW: begin
				mul_a = MW'(slew_d);
				mul_b = SLEW_S;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			smooth_q    <= '0;
			lvl_valid_q <= 1'b0;
			trim_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.div_init) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			// The first reading after an inactive spell seeds the filter.
			if (cmd.fill_load && !lvl_valid_q) begin
				smooth_q    <= fill_d;
				lvl_valid_q <= 1'b1;
			end
			if (cmd.smooth_upd) begin
				smooth_q <= smooth_sum[F:0];
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				if (inactive_q) begin
					trim_q      <= '0;
					smooth_q    <= '0;
					lvl_valid_q <= 1'b0;
				end else if (skip_q) begin
					trim_q <= '0;
				end else begin
					trim_q <= trim_run;
				end
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			inactive_q <= !machine_running || fast_forward || !audio_enabled;
			skip_q     <= (ring_capacity == '0) || !device_started;
			queued_q   <= buffered_samples;
			cap_q      <= ring_capacity;
		end
		if (cmd.div_init) begin
			sat_q <= queued_q >= cap_q;
			rem_q <= queued_q;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= div_ge ? div_sub[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
			quo_q <= {quo_q[F-2:0], div_ge};
		end
		if (cmd.fill_load) begin
			fill_q <= fill_d;
		end
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
			if (cmd.mul_sel == aflt_pkg::MUL_SQR) begin
				e_q <= err;
			end
		end
		if (cmd.goal_load) begin
			goal_q <= goal_d;
		end
		if (cmd.out_load) begin
			if (inactive_q) begin
				out_value_q <= '0;
				out_write_q <= (trim_q != '0);
			end else if (skip_q) begin
				out_value_q <= '0;
				out_write_q <= 1'b0;
			end else begin
				out_value_q <= trim_run;
				out_write_q <= 1'b1;
			end
		end
	end

	assign sts.inactive = inactive_q;
	assign sts.skip     = skip_q;
	assign sts.div_last = (cnt_q == CW'(F - 1));
	assign sts.out_free = !out_valid_q || !result_stall;

	assign result_valid = out_valid_q;
	assign trim_value   = out_value_q;
	assign trim_write   = out_write_q;

endmodule

/* rtl/core/audio_fifo_level_trim_loop_unit.sv */
`timescale 1ns / 1ps
// Sequence: an active tick goes through check, the one-bit-per-cycle fill
// divider, fill load and four passes of the shared multiplier (filter, square,
// cube, slew; filter update and goal load between) to the result register; an
// inactive tick, or one without a ring or started device, goes from check to
// the result. One word in flight; a stalled result holds off the next one.
// Reset: asynchronous, active low; clears loop state and result valid,
// and loads the register defaults (target 0.5, trim limit about 0.01).
// ----------------------------------------------------------------------------
// audio_fifo_level_trim_loop_unit: audio ring fill trim loop
// Smooths the ring fill level and slews a cubic resampler trim toward it.
// ----------------------------------------------------------------------------
module audio_fifo_level_trim_loop_unit #(
	parameter int COUNT_BITS = aflt_pkg::COUNT_BITS_DEF,
	parameter int FRAC_BITS  = aflt_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  logic                      machine_running,
	input  logic                      fast_forward,
	input  logic                      audio_enabled,
	input  logic                      device_started,
	input  logic [COUNT_BITS-1:0]     buffered_samples,
	input  logic [COUNT_BITS-1:0]     ring_capacity,
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic signed [FRAC_BITS:0] trim_value,
	output logic                      trim_write
);

	aflt_pkg::cmd_t       cmd;
	aflt_pkg::sts_t       sts;
	logic [FRAC_BITS:0]   target_level;
	logic [FRAC_BITS-1:0] max_trim;

	assign pready = 1'b1;

	aflt_regs #(
		.FRAC_BITS(FRAC_BITS)
	) u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.target_level (target_level),
		.max_trim     (max_trim)
	);

	aflt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	aflt_dp #(
		.COUNT_BITS(COUNT_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.machine_running  (machine_running),
		.fast_forward     (fast_forward),
		.audio_enabled    (audio_enabled),
		.device_started   (device_started),
		.buffered_samples (buffered_samples),
		.ring_capacity    (ring_capacity),
		.target_level     (target_level),
		.max_trim         (max_trim),
		.result_stall     (result_stall),
		.result_valid     (result_valid),
		.trim_value       (trim_value),
		.trim_write       (trim_write)
	);

endmodule

/* rtl/core/aflt_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aflt_checker: port-level checks for the trim loop
// Watches the word channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module aflt_checker #(
	parameter int FRAC_BITS = aflt_pkg::FRAC_BITS_DEF
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      item_valid,
	input logic                      item_stall,
	input logic                      result_valid,
	input logic                      result_stall,
	input logic signed [FRAC_BITS:0] trim_value,
	input logic                      trim_write
);

	// Only one word is worked on at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("input accepted while a word is still in progress");

	// A new result only appears as a word finishes.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result appeared without a word in progress");

	// A tick that does not push the trim always reports zero.
	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !trim_write |-> trim_value == '0)
		else $error("nonzero trim reported without a write");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(trim_value) && $stable(trim_write))
		else $error("stalled result changed");

endmodule

bind audio_fifo_level_trim_loop_unit aflt_checker #(
	.FRAC_BITS(FRAC_BITS)
) u_aflt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.trim_value   (trim_value),
	.trim_write   (trim_write)
);

/* tb/audio_fifo_level_trim_loop_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_fifo_level_trim_loop_unit_test: self-checking bench for the trim loop
// Drives frame ticks in random bursts against a stalling receiver, predicts
// every trim word in a scoreboard class and steps the APB registers between
// phases through their extremes and random settings.
// ----------------------------------------------------------------------------
module audio_fifo_level_trim_loop_unit_test;

	localparam int CNT_W           = aflt_pkg::COUNT_BITS_DEF;
	localparam int FRAC_W          = aflt_pkg::FRAC_BITS_DEF;
	localparam int IDLE_LIMIT      = 4000;
	localparam int PHASES          = 10;
	localparam int TICKS_PER_PHASE = 40;
	localparam int DRAIN_CYCLES    = 50;

	typedef struct packed {
		logic [FRAC_W:0] trim;
		logic            write;
	} trim_word_t;

	class trim_loop_tracker;
		longint     smoothed;
		bit         have_level;
		longint     trim_acc;
		longint     target;
		longint     limit;
		trim_word_t pending[$];
		int         mismatches;

		function new();
			smoothed   = 0;
			have_level = 0;
			trim_acc   = 0;
			target     = 8388608;
			limit      = 167772;
			mismatches = 0;
		endfunction

		function void set_reg(logic idx, logic [31:0] value);
			if (idx == aflt_pkg::REG_TARGET_LEVEL)
				target = longint'(value[FRAC_W:0]);
			else
				limit = longint'(value[FRAC_W-1:0]);
		endfunction

		// Works out the trim word for one accepted tick and queues it.
		function void predict_tick(bit run, bit ffwd, bit audio, bit started,
				logic [CNT_W-1:0] queued, logic [CNT_W-1:0] ring);
			longint     one_fix;
			longint     near_band;
			longint     fill;
			longint     band;
			longint     k;
			longint     e;
			longint     e2;
			longint     cube;
			longint     goal;
			trim_word_t w;
			one_fix   = longint'(1) << FRAC_W;
			near_band = (one_fix * 15) / 100;
			w         = '0;
			if (!run || ffwd || !audio) begin
				w.write    = (trim_acc != 0);
				trim_acc   = 0;
				smoothed   = 0;
				have_level = 0;
			end else if (ring == 0 || !started) begin
				trim_acc = 0;
			end else begin
				fill = (longint'(queued) << FRAC_W) / longint'(ring);
				if (fill > one_fix)
					fill = one_fix;
				if (!have_level) begin
					smoothed   = fill;
					have_level = 1;
				end
				band = fill - target;
				if (band < 0)
					band = -band;
				k = (band > near_band) ? aflt_pkg::FAST_K : aflt_pkg::SLOW_K;
				smoothed += ((fill - smoothed) * k) >>> aflt_pkg::K_BITS;
				e    = smoothed - target;
				e2   = (e * e) >>> FRAC_W;
				cube = (e2 * e) >>> FRAC_W;
				goal = cube * 2;
				if (goal > limit)
					goal = limit;
				if (goal < -limit)
					goal = -limit;
				trim_acc += ((goal - trim_acc) * aflt_pkg::SLEW_K) >>> aflt_pkg::K_BITS;
				w.trim  = (FRAC_W + 1)'(trim_acc);
				w.write = 1'b1;
			end
			pending.push_back(w);
		endfunction

		function void check_trim(logic [FRAC_W:0] trim, logic write);
			trim_word_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected trim word: trim %0d write %0b",
						$signed(trim), write);
				return;
			end
			want = pending.pop_front();
			if (trim !== want.trim || write !== want.write) begin
				mismatches++;
				if (mismatches <= 10)
					$display("trim mismatch: expected %0d/%0b, got %0d/%0b",
						$signed(want.trim), want.write, $signed(trim), write);
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [2:0]            paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  item_valid;
	logic                  item_stall;
	logic                  machine_running;
	logic                  fast_forward;
	logic                  audio_enabled;
	logic                  device_started;
	logic [CNT_W-1:0]      buffered_samples;
	logic [CNT_W-1:0]      ring_capacity;
	logic                  result_valid;
	logic                  result_stall;
	logic signed [FRAC_W:0] trim_value;
	logic                  trim_write;

	trim_loop_tracker tracker = new();

	int burst_left;
	int ring_size;
	int level_walk;
	int stall_mode;
	int stall_left;
	int idle_cycles;

	wire item_taken   = item_valid && !item_stall;
	wire result_taken = result_valid && !result_stall;

	audio_fifo_level_trim_loop_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.machine_running  (machine_running),
		.fast_forward     (fast_forward),
		.audio_enabled    (audio_enabled),
		.device_started   (device_started),
		.buffered_samples (buffered_samples),
		.ring_capacity    (ring_capacity),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.trim_value       (trim_value),
		.trim_write       (trim_write)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && result_taken)
			tracker.check_trim(trim_value, trim_write);
	end

	// The receiver alternates between free flow, random stalls and long stalls.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(8, 80);
		end
		stall_left--;
		case (stall_mode)
			0: begin
				result_stall <= 1'b0;
			end
			1: begin
				result_stall <= 1'($urandom);
			end
			default: begin
				result_stall <= (stall_left % 7) != 0;
			end
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || item_taken || result_taken)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
			$display("audio_fifo_level_trim_loop_unit regression: fail");
			$finish;
		end
	end

	task automatic reg_write(input logic idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tracker.set_reg(idx, value);
		@(posedge clk);
	endtask

	// Presents one tick, waits until it is taken, then maybe opens a gap.
	task automatic send_tick(input bit run, input bit ffwd, input bit audio,
			input bit started, input logic [CNT_W-1:0] queued,
			input logic [CNT_W-1:0] ring);
		int gap;
		item_valid       <= 1'b1;
		machine_running  <= run;
		fast_forward     <= ffwd;
		audio_enabled    <= audio;
		device_started   <= started;
		buffered_samples <= queued;
		ring_capacity    <= ring;
		do @(posedge clk); while (!item_taken);
		tracker.predict_tick(run, ffwd, audio, started, queued, ring);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_tick();
		int pick;
		int walk_step;
		int walk_top;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			send_tick(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
				CNT_W'($urandom), CNT_W'($urandom));
		end else if (pick < 15) begin
			// A running machine whose ring is absent or not yet draining.
			if (pick < 12)
				send_tick(1, 0, 1, 1, CNT_W'($urandom), '0);
			else
				send_tick(1, 0, 1, 0, CNT_W'($urandom), CNT_W'(ring_size));
		end else if (pick < 25) begin
			send_tick(1, 0, 1, 1, CNT_W'($urandom),
				CNT_W'($urandom_range(1, 65535)));
		end else begin
			walk_step  = ring_size / 16 + 1;
			level_walk += int'($urandom_range(0, 2 * walk_step)) - walk_step;
			walk_top   = ring_size + ring_size / 8;
			if (walk_top > 65535)
				walk_top = 65535;
			if (level_walk < 0)
				level_walk = 0;
			if (level_walk > walk_top)
				level_walk = walk_top;
			send_tick(1, 0, 1, 1, CNT_W'(level_walk), CNT_W'(ring_size));
		end
	endtask

	initial begin
		logic [31:0] target_set;
		logic [31:0] limit_set;
		int          pick;
		arst_n           <= 1'b0;
		psel             <= 1'b0;
		penable          <= 1'b0;
		pwrite           <= 1'b0;
		paddr            <= '0;
		pwdata           <= '0;
		item_valid       <= 1'b0;
		machine_running  <= 1'b0;
		fast_forward     <= 1'b0;
		audio_enabled    <= 1'b0;
		device_started   <= 1'b0;
		buffered_samples <= '0;
		ring_capacity    <= '0;
		result_stall     <= 1'b0;
		burst_left       = 1;
		stall_left       = 0;
		idle_cycles      = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed ticks at the reset register values.
		send_tick(0, 0, 0, 0, '0, '0);
		send_tick(1, 0, 1, 0, 16'd1000, 16'd1000);
		send_tick(1, 0, 1, 1, 16'd500, '0);
		send_tick(1, 0, 1, 1, '0, 16'd1000);
		send_tick(1, 0, 1, 1, 16'hffff, 16'hffff);
		send_tick(1, 0, 1, 1, 16'hffff, 16'd1);
		send_tick(1, 0, 1, 1, 16'd500, 16'd1000);
		send_tick(1, 0, 1, 1, 16'd600, 16'd1000);
		send_tick(1, 1, 1, 1, 16'd600, 16'd1000);
		send_tick(1, 1, 1, 1, 16'd600, 16'd1000);
		send_tick(1, 0, 1, 1, 16'd1, 16'hffff);
		send_tick(1, 0, 1, 1, '0, 16'hffff);
		send_tick(1, 0, 0, 1, '0, 16'hffff);
		send_tick(1, 0, 1, 1, 16'd40000, 16'd50000);
		send_tick(1, 0, 1, 1, 16'd50000, 16'd50000);
		send_tick(1, 0, 1, 0, 16'd50000, 16'd50000);
		send_tick(1, 0, 1, 1, 16'd45000, 16'd50000);
		send_tick(1, 0, 1, 1, 16'd45000, '0);
		send_tick(1, 0, 1, 1, 16'd49000, 16'd50000);
		send_tick(0, 1, 1, 1, 16'hffff, 16'hffff);
		send_tick(0, 1, 1, 1, 16'hffff, 16'hffff);
		send_tick(1, 0, 1, 1, 16'd2, 16'd3);
		settle();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					target_set = 32'd0;
					limit_set  = 32'd8388608;
				end
				1: begin
					target_set = 32'd16777216;
					limit_set  = 32'd0;
				end
				2: begin
					target_set = 32'h01ff_ffff;
					limit_set  = 32'h00ff_ffff;
				end
				3: begin
					target_set = 32'd8388608;
					limit_set  = 32'd167772;
				end
				default: begin
					if ($urandom_range(0, 3) == 0)
						target_set = $urandom & 32'h01ff_ffff;
					else
						target_set = $urandom_range(0, 16777216);
					if ($urandom_range(0, 1) == 0)
						limit_set = $urandom & 32'h00ff_ffff;
					else
						limit_set = $urandom_range(0, 1 << 20);
				end
			endcase
			reg_write(aflt_pkg::REG_TARGET_LEVEL, target_set);
			reg_write(aflt_pkg::REG_MAX_TRIM, limit_set);

			pick = $urandom_range(0, 3);
			if (pick == 0)
				ring_size = $urandom_range(1, 64);
			else if (pick == 1)
				ring_size = 65535;
			else
				ring_size = $urandom_range(1, 65535);
			level_walk = $urandom_range(0, ring_size);

			for (int n = 0; n < TICKS_PER_PHASE; n++)
				random_tick();
			settle();
		end

		if (tracker.mismatches == 0 && tracker.pending.size() == 0)
			$display("audio_fifo_level_trim_loop_unit regression: pass");
		else
			$display("audio_fifo_level_trim_loop_unit regression: fail");
		$finish;
	end

endmodule
